### hdl/mtfq_pkg.sv
// types and constants shared by the move-to-front round-robin queue
// no dependencies
`default_nettype none

package mtfq_pkg;

   localparam int ID_W = 30;

   typedef enum logic [1:0] {
      ACT_NEXT     = 2'd0,
      ACT_EXPEDITE = 2'd1,
      ACT_RESTART  = 2'd2
   } action_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic            rotate;
      logic            expedite;
      logic            restart;
      logic [ID_W-1:0] id;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### hdl/move_to_front_round_robin_queue_core.sv
// move-to-front round-robin queue: control, result register and the cell chain
// depends on mtfq_pkg and mtfq_cell
//
// Usage:
//  req channel (req_valid/req_ready) carries one command: req_action 0 serves
//  the front identifier and rotates it to the back, 1 moves req_person_id to
//  the front (inserting it when absent), 2 reloads 1..min(population, CAPACITY).
//  rsp channel (rsp_valid/rsp_ready) returns served_id and the sticky
//  overflowed flag, only for a serve on a non-empty queue.
//  csr channel (csr_valid/csr_ready) writes population; always ready.
//  All cells compare against the identifier and shift in the same cycle, and
//  the match is passed along the chain to decide which cells shift. A result
//  appears on rsp in the cycle after its transfer.
//  Throughput is one command per cycle while the receiver keeps up.
//  When rsp is stalled with a result pending, req_ready drops until it is taken.
//  Reset empties the queue, clears the overflow flag and sets population to 1;
//  entry contents are left as they are and are never read beyond the count.
`default_nettype none

module move_to_front_round_robin_queue_core #(
   parameter int CAPACITY = 64
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire [1:0]                   req_action,
   input  wire [mtfq_pkg::ID_W-1:0]    req_person_id,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic [mtfq_pkg::ID_W-1:0]   rsp_served_id,
   output logic                        rsp_overflowed,
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire [mtfq_pkg::ID_W-1:0]    csr_population
);
   import mtfq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [ID_W-1:0]  CAP_ID  = ID_W'(CAPACITY);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic [ID_W-1:0]  population_ff, population_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]  served_ff, served_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic             req_xfer;
   cell_ctrl_type    ctrl;
   logic [ID_W-1:0]  entry_w [CAPACITY];
   logic             found_w [CAPACITY+1];
   logic [ID_W-1:0]  front;

   assign req_ready      = !rsp_valid_ff || rsp_ready;
   assign req_xfer       = req_valid && req_ready;
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_served_id  = served_ff;
   assign rsp_overflowed = rsp_ovf_ff;
   assign front          = entry_w[0];

   always_comb begin
      ctrl          = '0;
      ctrl.id       = req_person_id;
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      population_in = csr_valid ? csr_population : population_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      served_in     = served_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      if (req_xfer) begin
         unique case (req_action)
            ACT_NEXT: begin
               if (count_ff != '0) begin
                  ctrl.rotate  = 1'b1;
                  rsp_valid_in = 1'b1;
                  served_in    = front;
                  rsp_ovf_in   = overflow_ff;
               end
            end
            ACT_EXPEDITE: begin
               ctrl.expedite = 1'b1;
               if (!found_w[CAPACITY]) begin
                  if (count_ff == CAP_CNT) begin
                     overflow_in = 1'b1;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end
            ACT_RESTART: begin
               ctrl.restart = 1'b1;
               count_in = (population_ff > CAP_ID) ? CAP_CNT : population_ff[CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         population_ff <= ID_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         overflow_ff   <= overflow_in;
         population_ff <= population_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      served_ff  <= served_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign found_w[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ID_W-1:0] left_w;
      logic [ID_W-1:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = req_person_id;
      end else begin : g_mid
         assign left_w = entry_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = front;
      end else begin : g_inner
         assign right_w = entry_w[i+1];
      end
      mtfq_cell #(
         .INDEX(i),
         .CNT_W(CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .left_entry (left_w),
         .right_entry(right_w),
         .front_entry(front),
         .found_in   (found_w[i]),
         .entry      (entry_w[i]),
         .found_out  (found_w[i+1])
      );
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("count above capacity");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("overflow flag cleared");

   a_serve_front: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_action == ACT_NEXT) && (count_ff != '0))
      |=> (rsp_valid_ff && (served_ff == $past(front))))
      else $error("served identifier is not the front entry");

   a_expedite_front: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_action == ACT_EXPEDITE)) |=> (front == $past(req_person_id)))
      else $error("expedited identifier not at front");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_action == ACT_EXPEDITE) && !found_w[CAPACITY]
       && (count_ff != CAP_CNT)) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow the queue");
`endif

endmodule

`default_nettype wire

### hdl/mtfq_cell.sv
// one queue slot: holds an entry and takes from its left or right neighbor, the front entry or its sequence number
// depends on mtfq_pkg
`default_nettype none

module mtfq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  wire                         clock,
   input  mtfq_pkg::cell_ctrl_type     ctrl,
   input  wire [CNT_W-1:0]             count,
   input  wire [mtfq_pkg::ID_W-1:0]    left_entry,
   input  wire [mtfq_pkg::ID_W-1:0]    right_entry,
   input  wire [mtfq_pkg::ID_W-1:0]    front_entry,
   input  wire                         found_in,
   output logic [mtfq_pkg::ID_W-1:0]   entry,
   output logic                        found_out
);
   import mtfq_pkg::*;

   localparam logic [CNT_W-1:0] IDX      = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(INDEX + 1);
   localparam logic [ID_W-1:0]  SEQ_ID   = ID_W'(INDEX + 1);

   logic [ID_W-1:0] entry_ff;
   logic [ID_W-1:0] entry_in;

   assign entry     = entry_ff;
   assign found_out = found_in | ((IDX < count) && (entry_ff == ctrl.id));

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.restart) begin
         entry_in = SEQ_ID;
      end else if (ctrl.expedite) begin
         // shift right up to the match, or all the way when absent
         if (!found_in) begin
            entry_in = left_entry;
         end
      end else if (ctrl.rotate) begin
         entry_in = (IDX_NEXT == count) ? front_entry : right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire
